[rtl/scan_code_to_char_queue_macros.svh]
// assertion macros used by the checker file
`ifndef SCAN_CODE_TO_CHAR_QUEUE_MACROS_SVH
`define SCAN_CODE_TO_CHAR_QUEUE_MACROS_SVH

// property checked outside reset
`define SCTCQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked during reset as well
`define SCTCQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/sctcq_pkg.sv]
package sctcq_pkg;

  // item kinds
  localparam logic [1:0] KIND_SCAN  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // special scan codes
  localparam logic [7:0] LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] EXT_PREFIX   = 8'hE0;

  localparam int NUM_CODES = 96;
  localparam logic [7:0] FIRST_EXT = 8'h45;
  localparam logic [7:0] LAST_EXT  = 8'h53;
  localparam int NUM_EXT = 15;

  localparam logic [7:0] PLAIN_TAB [NUM_CODES] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] SHIFT_TAB [NUM_CODES] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // extended keys from code 0x45 up: numlock, scroll lock, home, up, pgup, ...
  localparam logic [7:0] EXT_TAB [NUM_EXT] = '{
    8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h2D, 8'h85, 8'h00,
    8'h86, 8'h2B, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B
  };

  // translatable range is 0x01 .. 0x5F
  function automatic logic in_range(input logic [7:0] code);
    return (code != 8'h00) && (code < 8'(NUM_CODES));
  endfunction

  function automatic logic [7:0] norm_char(input logic [7:0] code, input logic shifted);
    logic [6:0] idx;
    idx = code[6:0];
    if (!in_range(code)) return 8'h00;
    return shifted ? SHIFT_TAB[idx] : PLAIN_TAB[idx];
  endfunction

  function automatic logic [7:0] ext_char(input logic [7:0] code);
    logic [7:0] off;
    off = code - FIRST_EXT;
    if (code < FIRST_EXT || code > LAST_EXT) return 8'h00;
    return EXT_TAB[off[3:0]];
  endfunction

  typedef struct packed {
    logic       push;
    logic [7:0] ch;
  } push_req_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       flush;
    logic [7:0] ch;
  } queue_cmd_t;

  typedef struct packed {
    logic stored;
    logic dropped;
    logic popped;
  } queue_status_t;

endpackage

[rtl/sctcq_in_if.sv]
interface sctcq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] scan_code;

  modport source (output valid, output kind, output scan_code, input ready);
  modport sink (input valid, input kind, input scan_code, output ready);
endinterface

[rtl/sctcq_out_if.sv]
interface sctcq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       char_valid;
  logic       stored;
  logic       dropped;

  modport source (output valid, output char_out, output char_valid, output stored,
                  output dropped, input ready);
  modport sink (input valid, input char_out, input char_valid, input stored,
                input dropped, output ready);
endinterface

[rtl/sctcq_decode.sv]
module sctcq_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            scan_code,
  output sctcq_pkg::push_req_t  push_req
);

  logic       shift_held;
  logic       shift_held_next;
  logic       prefix_pending;
  logic       prefix_pending_next;
  logic [7:0] ext_ch;

  assign ext_ch = sctcq_pkg::ext_char(scan_code);

  // scan byte interpretation
  always_comb begin
    shift_held_next     = shift_held;
    prefix_pending_next = prefix_pending;
    push_req.push       = 1'b0;
    push_req.ch         = 8'h00;
    if (take) begin
      priority if (prefix_pending) begin
        // byte after the prefix is always taken as an extended code
        prefix_pending_next = 1'b0;
        push_req.push       = (ext_ch != 8'h00);
        push_req.ch         = ext_ch;
      end else if (scan_code == sctcq_pkg::LSHIFT_MAKE ||
                   scan_code == sctcq_pkg::RSHIFT_MAKE) begin
        shift_held_next = 1'b1;
      end else if (scan_code == sctcq_pkg::LSHIFT_BREAK ||
                   scan_code == sctcq_pkg::RSHIFT_BREAK) begin
        shift_held_next = 1'b0;
      end else if (scan_code == sctcq_pkg::EXT_PREFIX) begin
        prefix_pending_next = 1'b1;
      end else begin
        // zero table entries are still queued as empty entries
        push_req.push = sctcq_pkg::in_range(scan_code);
        push_req.ch   = sctcq_pkg::norm_char(scan_code, shift_held);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held     <= 1'b0;
      prefix_pending <= 1'b0;
    end else begin
      shift_held     <= shift_held_next;
      prefix_pending <= prefix_pending_next;
    end
  end

endmodule

[rtl/sctcq_queue.sv]
module sctcq_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sctcq_pkg::queue_cmd_t     cmd,
  output sctcq_pkg::queue_status_t  status,
  output logic [7:0]                rd_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  logic [7:0]    mem [QUEUE_DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] tail_inc;
  logic          full;
  logic          empty;
  logic          do_write;
  logic          do_read;

  // ring pointer advance with wrap
  assign head_inc = (head == LAST) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST) ? '0 : tail + 1'b1;

  assign full     = (tail_inc == head);
  assign empty    = (head == tail);
  assign do_write = cmd.push && !full;
  assign do_read  = cmd.pop && !empty;

  assign status.stored  = do_write;
  assign status.dropped = cmd.push && full;
  assign status.popped  = do_read;

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (cmd.flush) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (do_write) tail <= tail_inc;
      if (do_read) head <= head_inc;
    end
  end

  // character storage, read data registered
  always_ff @(posedge clk) begin
    if (do_write) mem[tail] <= cmd.ch;
    if (do_read) rd_data <= mem[head];
  end

endmodule

[rtl/scan_code_to_char_queue.sv]
// Set-1 scan code to character queue.
// Channel req carries one item per transfer: kind selects a scan code byte,
// a read of the queue head, or a flush of the queue; scan_code is the raw byte.
// Channel rsp returns exactly one result per accepted item: char_out and
// char_valid for a read, stored or dropped for a scan code, all zero otherwise.
// A read that returns char_valid with char_out zero is an empty entry to skip.
// The result of an item accepted at one edge is offered on rsp right after it.
// Throughput is one item per cycle while rsp does not stall, set by the single
// output register; table lookup, queue pointer update and the queue memory
// access all complete in the accept cycle.
// When rsp is stalled, the waiting result holds and req.ready stays low until
// rsp takes it; req.ready is high whenever the output register is empty or
// being drained in the same cycle.
// Reset clears the shift and prefix flags, empties the queue and drops any
// pending result. The queue holds QUEUE_DEPTH - 1 characters; a character
// arriving on a full queue is lost and reported as dropped.
module scan_code_to_char_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  sctcq_in_if.sink           req,
  sctcq_out_if.source        rsp
);

  logic                     accept;
  logic                     out_valid;
  logic                     char_valid;
  logic                     stored;
  logic                     dropped;
  logic [7:0]               rd_data;
  sctcq_pkg::push_req_t     push_req;
  sctcq_pkg::queue_cmd_t    cmd;
  sctcq_pkg::queue_status_t status;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  sctcq_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .take      (accept && (req.kind == sctcq_pkg::KIND_SCAN)),
    .scan_code (req.scan_code),
    .push_req  (push_req)
  );

  // queue command for this transfer
  assign cmd.push  = push_req.push;
  assign cmd.ch    = push_req.ch;
  assign cmd.pop   = accept && (req.kind == sctcq_pkg::KIND_READ);
  assign cmd.flush = accept && (req.kind == sctcq_pkg::KIND_FLUSH);

  sctcq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .rd_data (rd_data)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result flags
  always_ff @(posedge clk) begin
    if (accept) begin
      char_valid <= status.popped;
      stored     <= status.stored;
      dropped    <= status.dropped;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.char_valid = char_valid;
  assign rsp.stored     = stored;
  assign rsp.dropped    = dropped;
  assign rsp.char_out   = char_valid ? rd_data : 8'h00;

endmodule

[rtl/sctcq_checker.sv]
`include "scan_code_to_char_queue_macros.svh"

module sctcq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_kind,
  input logic       out_valid,
  input logic [7:0] out_char,
  input logic       out_char_valid,
  input logic       out_stored,
  input logic       out_dropped
);

  // no result survives reset
  `SCTCQ_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "result valid after reset")

  // every transfer in yields a result next cycle
  `SCTCQ_ASSERT(a_one_result, (in_valid && in_ready) |=> out_valid, "missing result")

  // a result reports at most one outcome
  `SCTCQ_ASSERT(a_outcome, out_valid |-> $onehot0({out_char_valid, out_stored, out_dropped}),
    "conflicting result flags")

  // a character only comes with a successful read
  `SCTCQ_ASSERT(a_char_read, (out_valid && out_char != 8'h00) |-> out_char_valid,
    "character without read")

  // reads never store or drop
  `SCTCQ_ASSERT(a_read_no_store,
    (in_valid && in_ready && in_kind == sctcq_pkg::KIND_READ) |=> (!out_stored && !out_dropped),
    "read reported a store")

endmodule

bind scan_code_to_char_queue sctcq_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .in_kind        (req.kind),
  .out_valid      (rsp.valid),
  .out_char       (rsp.char_out),
  .out_char_valid (rsp.char_valid),
  .out_stored     (rsp.stored),
  .out_dropped    (rsp.dropped)
);

[tb/scan_code_to_char_queue_tb.sv]
module scan_code_to_char_queue_tb;

  localparam int QUEUE_DEPTH = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 220;

  // translatable and extended code ranges
  localparam logic [7:0] CODE_LIMIT = 8'h60;
  localparam logic [7:0] EXT_LO = 8'h45;
  localparam logic [7:0] EXT_HI = 8'h53;
  localparam logic [7:0] BREAK_BIT = 8'h80;

  // characters for codes 0x00..0x5f without shift
  localparam logic [7:0] LOWER_KEYS [96] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // characters for codes 0x00..0x5f with shift held
  localparam logic [7:0] UPPER_KEYS [96] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // extended keys for codes 0x45..0x53
  localparam logic [7:0] EXT_KEYS [15] = '{
    8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h2D, 8'h85, 8'h00,
    8'h86, 8'h2B, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] scan_code;
  } key_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       stored;
    logic       dropped;
  } char_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sctcq_in_if  req_if();
  sctcq_out_if rsp_if();

  scan_code_to_char_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  key_item_t    pending_keys [$];
  char_result_t expected_chars [$];
  key_item_t    next_key;
  char_result_t want;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           fail_count = 0;
  int           cycle_count = 0;

  // keyboard state as the block should hold it
  logic         shift_down = 1'b0;
  logic         ext_armed = 1'b0;
  logic [7:0]   ring [QUEUE_DEPTH];
  int           rd_ptr = 0;
  int           wr_ptr = 0;

  always #1 clk = ~clk;

  // translate one item against the keyboard state, return the expected result
  function automatic char_result_t translate_item(key_item_t it);
    char_result_t r;
    logic [7:0]   ch;
    logic         want_push;
    r = '0;
    ch = 8'h00;
    want_push = 1'b0;
    unique case (it.kind)
      sctcq_pkg::KIND_SCAN: begin
        if (ext_armed) begin
          ext_armed = 1'b0;
          if (it.scan_code >= EXT_LO && it.scan_code <= EXT_HI) begin
            ch = EXT_KEYS[it.scan_code - EXT_LO];
            want_push = (ch != 8'h00);
          end
        end else if (it.scan_code == sctcq_pkg::LSHIFT_MAKE ||
                     it.scan_code == sctcq_pkg::RSHIFT_MAKE) begin
          shift_down = 1'b1;
        end else if (it.scan_code == sctcq_pkg::LSHIFT_BREAK ||
                     it.scan_code == sctcq_pkg::RSHIFT_BREAK) begin
          shift_down = 1'b0;
        end else if (it.scan_code == sctcq_pkg::EXT_PREFIX) begin
          ext_armed = 1'b1;
        end else if (it.scan_code != 8'h00 && it.scan_code < CODE_LIMIT) begin
          ch = shift_down ? UPPER_KEYS[it.scan_code] : LOWER_KEYS[it.scan_code];
          want_push = 1'b1;
        end
        // ring keeps one slot free
        if (want_push) begin
          if ((wr_ptr + 1) % QUEUE_DEPTH == rd_ptr) begin
            r.dropped = 1'b1;
          end else begin
            ring[wr_ptr] = ch;
            wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
            r.stored = 1'b1;
          end
        end
      end
      sctcq_pkg::KIND_READ: begin
        if (rd_ptr != wr_ptr) begin
          r.char_out = ring[rd_ptr];
          r.char_valid = 1'b1;
          rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
        end
      end
      sctcq_pkg::KIND_FLUSH: begin
        rd_ptr = 0;
        wr_ptr = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_key(logic [1:0] kind, logic [7:0] code);
    key_item_t it;
    it.kind = kind;
    it.scan_code = code;
    pending_keys.push_back(it);
  endtask

  // typing bursts, extended keys, read runs, flushes and noise
  task automatic gen_phase(int budget);
    int         made;
    int         n;
    int         pick;
    logic [7:0] code;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(40, 25) : $urandom_range(12, 1);
        if ($urandom_range(2) == 0)
          add_key(sctcq_pkg::KIND_SCAN,
                  $urandom_range(1) ? sctcq_pkg::LSHIFT_MAKE : sctcq_pkg::RSHIFT_MAKE);
        repeat (n) begin
          code = 8'($urandom_range(CODE_LIMIT - 1, 1));
          add_key(sctcq_pkg::KIND_SCAN, code);
          if ($urandom_range(1)) add_key(sctcq_pkg::KIND_SCAN, code | BREAK_BIT);
          made++;
        end
        if ($urandom_range(1))
          add_key(sctcq_pkg::KIND_SCAN,
                  $urandom_range(1) ? sctcq_pkg::LSHIFT_BREAK : sctcq_pkg::RSHIFT_BREAK);
      end else if (pick < 55) begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          add_key(sctcq_pkg::KIND_SCAN, sctcq_pkg::EXT_PREFIX);
          if ($urandom_range(3) == 0) code = 8'($urandom);
          else code = 8'($urandom_range(EXT_HI, EXT_LO));
          add_key(sctcq_pkg::KIND_SCAN, code);
          made++;
        end
      end else if (pick < 85) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
        repeat (n) begin
          add_key(sctcq_pkg::KIND_READ, 8'($urandom));
          made++;
        end
      end else if (pick < 90) begin
        add_key(sctcq_pkg::KIND_FLUSH, 8'($urandom));
        made++;
      end else begin
        n = $urandom_range(8, 1);
        repeat (n) begin
          add_key(2'($urandom_range(3)), 8'($urandom));
          made++;
        end
      end
    end
  endtask

  // sender stops until every transfer has been answered
  task automatic wait_idle();
    while (pending_keys.size() != 0 || req_if.valid || expected_chars.size() != 0)
      @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_key = pending_keys.pop_front();
        req_if.valid <= 1'b1;
        req_if.kind <= next_key.kind;
        req_if.scan_code <= next_key.scan_code;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response monitor, then prediction of the request accepted at this edge
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected result char_out=%h char_valid=%b stored=%b dropped=%b",
                   $time, rsp_if.char_out, rsp_if.char_valid, rsp_if.stored,
                   rsp_if.dropped);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if ({rsp_if.char_out, rsp_if.char_valid, rsp_if.stored, rsp_if.dropped} !== want)
          begin
            $display("%0t: mismatch expected char_out=%h char_valid=%b stored=%b dropped=%b",
                     $time, want.char_out, want.char_valid, want.stored, want.dropped);
            $display("%0t:          actual char_out=%h char_valid=%b stored=%b dropped=%b",
                     $time, rsp_if.char_out, rsp_if.char_valid, rsp_if.stored,
                     rsp_if.dropped);
            fail_count++;
          end
        end
      end
      if (req_if.valid && req_if.ready)
        expected_chars.push_back(translate_item({req_if.kind, req_if.scan_code}));
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.kind = sctcq_pkg::KIND_SCAN;
    req_if.scan_code = 8'h00;
    rsp_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: code extremes, shift, prefix cases, empty entries, reads, flush
    add_key(sctcq_pkg::KIND_SCAN, 8'h00);
    add_key(sctcq_pkg::KIND_SCAN, 8'h01);
    add_key(sctcq_pkg::KIND_SCAN, 8'(CODE_LIMIT - 1));
    add_key(sctcq_pkg::KIND_SCAN, 8'hFF);
    add_key(sctcq_pkg::KIND_SCAN, sctcq_pkg::LSHIFT_MAKE);
    add_key(sctcq_pkg::KIND_SCAN, 8'h02);
    add_key(sctcq_pkg::KIND_SCAN, sctcq_pkg::LSHIFT_BREAK);
    add_key(sctcq_pkg::KIND_SCAN, sctcq_pkg::EXT_PREFIX);
    add_key(sctcq_pkg::KIND_SCAN, EXT_LO);
    add_key(sctcq_pkg::KIND_SCAN, sctcq_pkg::EXT_PREFIX);
    add_key(sctcq_pkg::KIND_SCAN, 8'h4C);
    add_key(sctcq_pkg::KIND_SCAN, sctcq_pkg::EXT_PREFIX);
    add_key(sctcq_pkg::KIND_SCAN, sctcq_pkg::EXT_PREFIX);
    add_key(sctcq_pkg::KIND_SCAN, sctcq_pkg::EXT_PREFIX);
    add_key(sctcq_pkg::KIND_SCAN, sctcq_pkg::LSHIFT_MAKE);
    add_key(sctcq_pkg::KIND_SCAN, 8'h1D);
    repeat (3) add_key(sctcq_pkg::KIND_READ, 8'h00);
    add_key(sctcq_pkg::KIND_FLUSH, 8'hFF);
    add_key(sctcq_pkg::KIND_READ, 8'hFF);
    add_key(2'd3, 8'h5A);
    wait_idle();

    // random phases with different idling
    gen_phase(RANDOM_PER_PHASE);
    wait_idle();
    send_idle_pct = 85;
    gen_phase(RANDOM_PER_PHASE);
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 85;
    gen_phase(RANDOM_PER_PHASE);
    wait_idle();
    send_idle_pct = 12;
    recv_stall_pct = 12;
    gen_phase(RANDOM_PER_PHASE);
    wait_idle();
    repeat (10) @(negedge clk);

    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[scan_code_to_char_queue.f]
+incdir+rtl
rtl/sctcq_pkg.sv
rtl/sctcq_in_if.sv
rtl/sctcq_out_if.sv
rtl/sctcq_decode.sv
rtl/sctcq_queue.sv
rtl/scan_code_to_char_queue.sv
rtl/sctcq_checker.sv
tb/scan_code_to_char_queue_tb.sv
